[design/lhfm_pkg.sv]
package lhfm_pkg;

    localparam int CFG_W     = 12;
    localparam int IDX_W     = 4;
    localparam int LUMA_W    = 8;
    localparam int BINS      = 256;
    localparam int BIN_W     = $clog2(BINS);
    localparam int CNT_W     = 23;
    localparam int FOCUS_W   = 31;
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [FOCUS_W-1:0] FOCUS_MAX = {FOCUS_W{1'b1}};

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

    // classified item handed from front to back
    typedef struct packed {
        logic             is_read;
        logic [BIN_W-1:0] key;
        logic             first;
        logic             add_right;
        logic             add_down;
        logic             is_last;
    } t_op;

    typedef struct packed {
        logic               is_bin_readout;
        logic [CNT_W-1:0]   bin_count;
        logic [FOCUS_W-1:0] focus_sum;
    } t_res;

endpackage

[design/lhfm_ifs.sv]
interface lhfm_pix_if;
    import lhfm_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [LUMA_W-1:0] luma;
    logic [BIN_W-1:0]  bin_index;

    modport source (output valid, action, luma, bin_index, input ready);
    modport sink   (input valid, action, luma, bin_index, output ready);
endinterface

interface lhfm_res_if;
    import lhfm_pkg::*;

    logic               valid;
    logic               ready;
    logic               is_bin_readout;
    logic [CNT_W-1:0]   bin_count;
    logic [FOCUS_W-1:0] focus_sum;

    modport source (output valid, is_bin_readout, bin_count, focus_sum, input ready);
    modport sink   (input valid, is_bin_readout, bin_count, focus_sum, output ready);
endinterface

interface lhfm_cfg_if;
    import lhfm_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/lhfm_fifo.sv]
module lhfm_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [W-1:0]                   i_data,
    output logic                           o_space,
    input  logic                           i_pop,
    output logic                           o_valid,
    output logic [W-1:0]                   o_data,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail = (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + PW'(1);
        end
        if (i_pop) begin
            n_head = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    assign o_space = (r_count < CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head];
    assign o_count = r_count;
endmodule

[design/lhfm_front.sv]
module lhfm_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lhfm_pix_if.sink                       i_pix,
    lhfm_cfg_if.sink                       i_cfg,
    input  logic                           i_space,
    output logic                           o_push,
    output lhfm_pkg::t_op                  o_op,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_slot
);
    import lhfm_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WEW = $clog2(MAX_WIDTH + 1);
    localparam int HEW = $clog2(MAX_HEIGHT + 1);
    localparam int WCW = (CFG_W > WEW) ? CFG_W : WEW;
    localparam int HCW = (CFG_W > HEW) ? CFG_W : HEW;

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;

    logic [WCW-1:0] width_ext, width_eff;
    logic [HCW-1:0] height_ext, height_eff;
    logic           last_col, last_row;
    logic           accept;

    always_comb begin
        width_ext  = WCW'(r_width);
        height_ext = HCW'(r_height);
        if (width_ext < WCW'(2)) begin
            width_eff = WCW'(2);
        end else if (width_ext > WCW'(MAX_WIDTH)) begin
            width_eff = WCW'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        if (height_ext < HCW'(2)) begin
            height_eff = HCW'(2);
        end else if (height_ext > HCW'(MAX_HEIGHT)) begin
            height_eff = HCW'(MAX_HEIGHT);
        end else begin
            height_eff = height_ext;
        end
    end

    assign last_col = (WCW'(r_col) >= width_eff - WCW'(1));
    assign last_row = (HCW'(r_row) >= height_eff - HCW'(1));

    assign i_pix.ready = i_space;
    assign accept      = i_pix.valid && i_space;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        o_op.is_read   = i_pix.action;
        o_op.key       = i_pix.action ? i_pix.bin_index : i_pix.luma;
        o_op.first     = !i_pix.action && (r_col == '0) && (r_row == '0);
        o_op.add_right = !i_pix.action && (r_col != '0) && !last_row;
        o_op.add_down  = !i_pix.action && (r_row != '0) && !last_col;
        o_op.is_last   = !i_pix.action && last_col && last_row;
    end

    assign o_push = accept;
    assign o_slot = r_col;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept && !i_pix.action) begin
            if (!last_col) begin
                n_col = r_col + CW'(1);
            end else begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_FRAME_WIDTH:  r_width  <= i_cfg.data;
                    REG_FRAME_HEIGHT: r_height <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end
endmodule

[design/lhfm_back.sv]
module lhfm_back #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  lhfm_pkg::t_op                  i_op,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_slot,
    output logic                           o_pop,
    input  logic [lhfm_pkg::OUT_CNT_W-1:0] i_out_count,
    input  logic                           i_out_pop,
    output logic                           o_push,
    output lhfm_pkg::t_res                 o_res
);
    import lhfm_pkg::*;

    localparam int SW = OUT_CNT_W + 1;

    logic [CNT_W-1:0]  r_hist [BINS];
    logic [LUMA_W-1:0] r_line [MAX_WIDTH];
    logic [BINS-1:0]   r_hist_vld;

    logic              r_s1_valid;
    t_op               r_s1_op;
    logic [LUMA_W-1:0] r_s1_left;
    logic [CNT_W-1:0]  r_hist_q;
    logic [LUMA_W-1:0] r_up_q;
    logic [LUMA_W-1:0] r_left;

    logic              r_wr_en;
    logic [BIN_W-1:0]  r_wr_bin;
    logic [CNT_W-1:0]  r_wr_val;

    logic [FOCUS_W-1:0] r_run;
    logic [FOCUS_W-1:0] r_last;

    logic [CNT_W-1:0]   old_cnt, n_cnt;
    logic [LUMA_W-1:0]  diff_right, diff_down;
    logic [FOCUS_W:0]   sum;
    logic [FOCUS_W-1:0] n_run;
    logic               px;

    // only take an item when the output buffer has room for whatever is in flight
    assign o_pop = i_valid &&
        (SW'(i_out_count) + SW'(r_s1_valid) < SW'(OUT_DEPTH) + SW'(i_out_pop));

    assign px = r_s1_valid && !r_s1_op.is_read;

    always_comb begin
        if (r_wr_en && (r_wr_bin == r_s1_op.key)) begin
            old_cnt = r_wr_val;
        end else if (r_hist_vld[r_s1_op.key]) begin
            old_cnt = r_hist_q;
        end else begin
            old_cnt = '0;
        end
        if (r_s1_op.first) begin
            old_cnt = '0;
        end
        n_cnt = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + CNT_W'(1);

        diff_right = (r_s1_op.key > r_s1_left) ? r_s1_op.key - r_s1_left
                                               : r_s1_left - r_s1_op.key;
        diff_down  = (r_s1_op.key > r_up_q) ? r_s1_op.key - r_up_q
                                            : r_up_q - r_s1_op.key;
        if (!r_s1_op.add_right) begin
            diff_right = '0;
        end
        if (!r_s1_op.add_down) begin
            diff_down = '0;
        end
        sum = (r_s1_op.first ? '0 : {1'b0, r_run})
            + (FOCUS_W + 1)'(diff_right) + (FOCUS_W + 1)'(diff_down);
        n_run = (sum > (FOCUS_W + 1)'(FOCUS_MAX)) ? FOCUS_MAX : sum[FOCUS_W-1:0];
    end

    always_comb begin
        o_push = r_s1_valid && (r_s1_op.is_read || r_s1_op.is_last);
        o_res.is_bin_readout = r_s1_op.is_read;
        o_res.bin_count      = r_s1_op.is_read ? old_cnt : '0;
        o_res.focus_sum      = r_s1_op.is_read ? r_last : n_run;
    end

    // memory reads and line store update at issue
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hist_q  <= r_hist[i_op.key];
            r_up_q    <= r_line[i_slot];
            r_s1_op   <= i_op;
            r_s1_left <= r_left;
            if (!i_op.is_read) begin
                r_line[i_slot] <= i_op.key;
            end
        end
        if (px) begin
            r_hist[r_s1_op.key] <= n_cnt;
        end
        r_wr_bin <= r_s1_op.key;
        r_wr_val <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_left     <= '0;
            r_hist_vld <= '0;
            r_wr_en    <= 1'b0;
            r_run      <= '0;
            r_last     <= '0;
        end else begin
            r_s1_valid <= o_pop;
            r_wr_en    <= px;
            if (o_pop && !i_op.is_read) begin
                r_left <= i_op.key;
            end
            if (px) begin
                r_run <= n_run;
                if (r_s1_op.first) begin
                    r_hist_vld <= BINS'(1) << r_s1_op.key;
                end else begin
                    r_hist_vld[r_s1_op.key] <= 1'b1;
                end
                if (r_s1_op.is_last) begin
                    r_last <= n_run;
                end
            end
        end
    end
endmodule

[design/luma_histogram_focus_metric_unit.sv]
// channel  dir  payload                                   beat taken when
// i_pix    in   action, luma, bin_index                   valid && ready
// o_res    out  is_bin_readout, bin_count, focus_sum      valid && ready
// i_cfg    in   index, data (0 frame_width, 1 frame_height) valid && ready
//
// one item per clock sustained while o_res is ready, pixels and bin reads alike; a
// result passes the item queue, the memory read and update stage, and the output buffer
// the histogram takes one read and one write per clock, a bypass covers back-to-back hits
// synchronous reset clears counters, histogram valid bits and sums;
// the line store is not cleared and needs no pass
// a stall on o_res fills the output buffer, then the item queue, then drops i_pix.ready
module luma_histogram_focus_metric_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lhfm_pix_if.sink   i_pix,
    lhfm_cfg_if.sink   i_cfg,
    lhfm_res_if.source o_res
);
    import lhfm_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int OPW   = $bits(t_op);
    localparam int MIDW  = OPW + CW;
    localparam int MCW   = $clog2(MID_DEPTH + 1);
    localparam int RESW  = $bits(t_res);

    logic            front_push;
    t_op             front_op;
    logic [CW-1:0]   front_slot;
    logic            mid_space;
    logic            mid_valid;
    logic [MIDW-1:0] mid_out;
    logic [MCW-1:0]  mid_count;
    logic            back_pop;
    t_op             back_op;

    logic                 res_push;
    t_res                 res;
    logic                 out_valid;
    logic [RESW-1:0]      out_data;
    logic [OUT_CNT_W-1:0] out_count;
    logic                 out_space;
    logic                 out_pop;
    t_res                 out_res;

    lhfm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (i_cfg),
        .i_space (mid_space),
        .o_push  (front_push),
        .o_op    (front_op),
        .o_slot  (front_slot)
    );

    lhfm_fifo #(
        .W     (MIDW),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  ({front_slot, front_op}),
        .o_space (mid_space),
        .i_pop   (back_pop),
        .o_valid (mid_valid),
        .o_data  (mid_out),
        .o_count (mid_count)
    );

    assign back_op = t_op'(mid_out[OPW-1:0]);

    lhfm_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (mid_valid),
        .i_op        (back_op),
        .i_slot      (mid_out[MIDW-1:OPW]),
        .o_pop       (back_pop),
        .i_out_count (out_count),
        .i_out_pop   (out_pop),
        .o_push      (res_push),
        .o_res       (res)
    );

    lhfm_fifo #(
        .W     (RESW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_space (out_space),
        .i_pop   (out_pop),
        .o_valid (out_valid),
        .o_data  (out_data),
        .o_count (out_count)
    );

    assign out_pop              = out_valid && o_res.ready;
    assign out_res              = t_res'(out_data);
    assign o_res.valid          = out_valid;
    assign o_res.is_bin_readout = out_res.is_bin_readout;
    assign o_res.bin_count      = out_res.bin_count;
    assign o_res.focus_sum      = out_res.focus_sum;

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> out_space)
        else $error("result written into a full output buffer");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_pop |-> mid_valid)
        else $error("back end took from an empty queue");

    a_mid_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |-> (mid_count < MCW'(MID_DEPTH)))
        else $error("item taken with the queue full");

    a_frame_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.is_bin_readout) |-> (o_res.bin_count == '0))
        else $error("frame report carries a bin count");
endmodule

[tb/luma_histogram_focus_metric_unit_tb.sv]
module luma_histogram_focus_metric_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lhfm_pkg::*;

    localparam int MAX_W        = 2048;
    localparam int MAX_H        = 2048;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 300;
    localparam int LONG_RUN     = 48;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef enum int {LUMA_ANY, LUMA_CHECKER, LUMA_PALETTE} t_luma_style;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lhfm_pix_if pix_if();
    lhfm_cfg_if cfg_if();
    lhfm_res_if res_if();

    luma_histogram_focus_metric_unit #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_if),
        .i_cfg  (cfg_if),
        .o_res  (res_if)
    );

    always #4 i_clk = ~i_clk;

    // predicted block state
    logic [CFG_W-1:0]   width_reg  = WIDTH_RESET;
    logic [CFG_W-1:0]   height_reg = HEIGHT_RESET;
    logic [CNT_W-1:0]   bin_tally[BINS] = '{default: '0};
    logic [LUMA_W-1:0]  line_store[MAX_W] = '{default: '0};
    logic [LUMA_W-1:0]  prev_luma  = '0;
    int unsigned        col_pos    = 0;
    int unsigned        row_pos    = 0;
    logic [FOCUS_W-1:0] focus_acc  = '0;
    logic [FOCUS_W-1:0] focus_done = '0;

    t_res owed_reports[$];
    int unsigned mismatches = 0;
    bit jitter_on = 1'b1;
    bit hold_request = 1'b0;

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        return v < 2 ? 2 : (v > hi ? hi : v);
    endfunction

    function automatic logic [FOCUS_W-1:0] focus_add(input logic [FOCUS_W-1:0] acc,
                                                     input logic [LUMA_W-1:0] a,
                                                     input logic [LUMA_W-1:0] b);
        logic [FOCUS_W:0] sum;
        sum = acc + (a > b ? a - b : b - a);
        return sum > FOCUS_MAX ? FOCUS_MAX : sum[FOCUS_W-1:0];
    endfunction

    function automatic void histo_focus_step(input logic act, input logic [LUMA_W-1:0] lu,
                                             input logic [BIN_W-1:0] bi);
        int unsigned w;
        int unsigned h;
        int unsigned slot;
        bit last_col;
        bit last_row;
        if (act == ACT_READ) begin
            owed_reports.push_back(t_res'{1'b1, bin_tally[bi], focus_done});
            return;
        end
        w        = clamp_size(width_reg, MAX_W);
        h        = clamp_size(height_reg, MAX_H);
        last_col = col_pos >= w - 1;
        last_row = row_pos >= h - 1;
        slot     = col_pos < MAX_W ? col_pos : MAX_W - 1;
        if (col_pos == 0 && row_pos == 0) begin
            foreach (bin_tally[i]) bin_tally[i] = '0;
            focus_acc = '0;
        end
        if (bin_tally[lu] != CNT_MAX) bin_tally[lu] = bin_tally[lu] + 1'b1;
        if (col_pos >= 1 && !last_row) focus_acc = focus_add(focus_acc, lu, prev_luma);
        if (row_pos >= 1 && !last_col) focus_acc = focus_add(focus_acc, lu, line_store[slot]);
        line_store[slot] = lu;
        prev_luma        = lu;
        if (!last_col) begin
            col_pos++;
        end else begin
            col_pos = 0;
            if (!last_row) begin
                row_pos++;
            end else begin
                row_pos    = 0;
                focus_done = focus_acc;
                owed_reports.push_back(t_res'{1'b0, '0, focus_acc});
            end
        end
    endfunction

    function automatic int unsigned gap_cycles();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [LUMA_W-1:0] pick_luma(input t_luma_style style);
        case (style)
            LUMA_CHECKER: return ((col_pos + row_pos) % 2) ? 8'hFF : 8'h00;
            LUMA_PALETTE: return $urandom_range(0, 1) ? LUMA_W'($urandom_range(0, 3))
                                                      : LUMA_W'($urandom_range(252, 255));
            default:      return LUMA_W'($urandom);
        endcase
    endfunction

    function automatic logic [BIN_W-1:0] pick_bin();
        return $urandom_range(0, 1) ? BIN_W'($urandom) : pick_luma(LUMA_PALETTE);
    endfunction

    task automatic send_beat(input logic act, input logic [LUMA_W-1:0] lu,
                             input logic [BIN_W-1:0] bi);
        int unsigned gap;
        gap = (jitter_on && $urandom_range(0, 2) == 0) ? gap_cycles() : 0;
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid     <= 1'b1;
        pix_if.action    <= act;
        pix_if.luma      <= lu;
        pix_if.bin_index <= bi;
        do @(posedge i_clk); while (!pix_if.ready);
        histo_focus_step(act, lu, bi);
    endtask

    task automatic send_pixel(input logic [LUMA_W-1:0] lu);
        send_beat(ACT_PIXEL, lu, BIN_W'($urandom));
    endtask

    task automatic read_bin(input logic [BIN_W-1:0] bi);
        send_beat(ACT_READ, LUMA_W'($urandom), bi);
    endtask

    task automatic finish_frame(input t_luma_style style);
        do send_pixel(pick_luma(style)); while (col_pos != 0 || row_pos != 0);
    endtask

    task automatic pause_until_drained();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (owed_reports.size() != 0) @(posedge i_clk);
    endtask

    // pixels in flight leave no result, so let the pipeline empty too
    task automatic drain_and_settle();
        pause_until_drained();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == REG_FRAME_WIDTH) width_reg = value;
        else if (idx == REG_FRAME_HEIGHT) height_reg = value;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        read_bin(8'h00);
        read_bin(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h5A);
        send_pixel(8'h5A);
        send_pixel(8'hA5);
        read_bin(8'h5A);
        read_bin(8'hFF);
    endtask

    // a long first row writes every line store slot that later size changes reach
    task automatic test_widest_frame();
        drain_and_settle();
        write_reg(REG_FRAME_WIDTH, 12'hFFF);
        write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
        repeat (LONG_RUN) send_pixel(pick_luma(LUMA_CHECKER));
        drain_and_settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(2));
        finish_frame(LUMA_CHECKER);
        read_bin(8'h00);
        read_bin(8'hFF);
    endtask

    task automatic test_tallest_frame();
        drain_and_settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(1));
        write_reg(REG_FRAME_HEIGHT, 12'hFFF);
        write_reg(IDX_W'(2), 12'hFFF);
        write_reg({IDX_W{1'b1}}, '0);
        repeat (LONG_RUN) send_pixel(pick_luma(LUMA_ANY));
        drain_and_settle();
        write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
        finish_frame(LUMA_ANY);
        read_bin(pick_bin());
        read_bin(8'h80);
    endtask

    task automatic test_size_change_mid_frame();
        drain_and_settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(5));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(4));
        repeat (7) send_pixel(pick_luma(LUMA_PALETTE));
        read_bin(8'h01);
        drain_and_settle();
        // position now on the new last column and last row
        write_reg(REG_FRAME_WIDTH, CFG_W'(3));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
        finish_frame(LUMA_PALETTE);
        drain_and_settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(4));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(5));
        repeat (10) send_pixel(pick_luma(LUMA_ANY));
        drain_and_settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(8));
        write_reg(REG_FRAME_HEIGHT, '0);
        finish_frame(LUMA_ANY);
        read_bin(pick_bin());
    endtask

    task automatic test_result_backpressure();
        drain_and_settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(2));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
        jitter_on    = 1'b0;
        hold_request = 1'b1;
        repeat (60) begin
            if ($urandom_range(0, 2) == 0) read_bin(pick_bin());
            else send_pixel(pick_luma(LUMA_PALETTE));
        end
        jitter_on = 1'b1;
    endtask

    task automatic test_back_to_back_frames();
        drain_and_settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(3));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
        jitter_on = 1'b0;
        repeat (4) begin
            finish_frame(LUMA_ANY);
            read_bin(pick_bin());
        end
        jitter_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int unsigned sent;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        t_luma_style style;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_and_settle();
            jitter_on = ($urandom_range(0, 4) != 0);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1)
              : ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(2, 10);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1)
              : ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(2, 6);
            write_reg(REG_FRAME_WIDTH, CFG_W'(w));
            write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
            if ($urandom_range(0, 9) == 0)
                write_reg(IDX_W'($urandom_range(2, 15)), CFG_W'($urandom));
            style = t_luma_style'($urandom_range(0, 2));
            // whole frames, sometimes with a partial one cut off by the next size change
            n = clamp_size(w, MAX_W) * clamp_size(h, MAX_H) * $urandom_range(1, 3);
            if ($urandom_range(0, 2) == 0) n += $urandom_range(1, 5);
            while (n != 0) begin
                if ($urandom_range(0, 5) == 0) begin
                    read_bin(pick_bin());
                end else begin
                    send_pixel(pick_luma(style));
                    n--;
                end
                sent++;
                if ($urandom_range(0, 99) == 0) pause_until_drained();
            end
        end
        jitter_on = 1'b1;
    endtask

    initial begin
        pix_if.valid     <= 1'b0;
        pix_if.action    <= ACT_PIXEL;
        pix_if.luma      <= '0;
        pix_if.bin_index <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= '0;
        cfg_if.data      <= '0;
        i_rst_n          <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_widest_frame();
        test_tallest_frame();
        test_size_change_mid_frame();
        test_result_backpressure();
        test_back_to_back_frames();
        test_random_frames();
        drain_and_settle();
        if (mismatches == 0 && owed_reports.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin : result_sink
        int unsigned n;
        forever begin
            if (hold_request) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (jitter_on && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat (gap_cycles()) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (owed_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: readout %0b count %0d focus %0d",
                             res_if.is_bin_readout, res_if.bin_count, res_if.focus_sum);
            end else begin
                want = owed_reports.pop_front();
                if (want.is_bin_readout !== res_if.is_bin_readout ||
                    want.bin_count !== res_if.bin_count ||
                    want.focus_sum !== res_if.focus_sum) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected readout %0b count %0d focus %0d,",
                                  " got %0b %0d %0d"},
                                 want.is_bin_readout, want.bin_count, want.focus_sum,
                                 res_if.is_bin_readout, res_if.bin_count, res_if.focus_sum);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/lhfm_pkg.sv
design/lhfm_ifs.sv
design/lhfm_fifo.sv
design/lhfm_front.sv
design/lhfm_back.sv
design/luma_histogram_focus_metric_unit.sv
tb/luma_histogram_focus_metric_unit_tb.sv
